### sv/hps_pkg.sv
// hps_pkg: shared types and constants for the Heap permutation stepper.
// Used by hps_counters and heap_permutation_stepper_core; no dependencies.
`default_nettype none

package hps_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int ADDR_W      = $clog2(MAX_SIZE);  // list position / counter width
  localparam int SIZE_W      = 5;                 // perm_size register width
  localparam int IDX_W       = 4;                 // elem_index field width

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_RESTART = 2'd1,
    FN_NEXT    = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_EMPTY  = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_NEW    = 2'd2,
    STAT_ACCESS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWAP_RB,
    S_SWAP_WA,
    S_SWAP_WB,
    S_FINISH
  } hps_state_t;

  typedef struct packed {
    logic clear_all;
    logic step;
  } ctr_cmd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] cnt;
  } ctr_hit_t;

endpackage

`default_nettype wire

### sv/hps_ram.sv
// hps_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module hps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/hps_counters.sv
// hps_counters: Heap swap counter bank with lowest-position search.
// Depends on hps_pkg.
`default_nettype none

module hps_counters
  import hps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [SIZE_W-1:0] eff_size,
  input  wire ctr_cmd_t          cmd,
  output ctr_hit_t               hit
);

  logic [ADDR_W-1:0] cnt_r [MAX_SIZE];

  // lowest position below eff_size whose counter is still below the position
  always_comb begin
    hit = '0;
    for (int i = MAX_SIZE - 1; i >= 0; i--) begin
      if (SIZE_W'(i) < eff_size && cnt_r[i] < ADDR_W'(i)) begin
        hit.found = 1'b1;
        hit.pos   = ADDR_W'(i);
      end
    end
    hit.cnt = cnt_r[hit.pos];
  end

  // counters hold no meaning until the first Next clears them
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_SIZE; j++) begin
      if (cmd.clear_all) begin
        cnt_r[j] <= '0;
      end else if (cmd.step) begin
        if (ADDR_W'(j) < hit.pos) begin
          cnt_r[j] <= '0;
        end else if (ADDR_W'(j) == hit.pos) begin
          cnt_r[j] <= cnt_r[j] + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/heap_permutation_stepper_core.sv
// heap_permutation_stepper_core: top level, control FSM and result register.
// Depends on hps_pkg, hps_ram and hps_counters.
//
// Usage:
//   in_*  channel: one transaction per operation. in_tuser carries the
//         operation (load, restart, next, read); in_tdata carries the list
//         position and the value to load.
//   out_* channel: exactly one transaction per input transaction, in order.
//         out_tuser is the status, out_tdata the element read (zero for
//         anything but a read).
//   cfg_*: perm_size, written when cfg_we is high; values above 16 act
//         as 16. Write only while the block is idle.
// Timing: the list sits in a 1R1W RAM with registered read. Load, restart and
//   a Next that does not swap go through S_FINISH, a read through S_READ and
//   S_FINISH, and a Next that swaps through S_SWAP_RB, S_SWAP_WA, S_SWAP_WB and
//   S_FINISH (two reads and two writes through the one RAM port pair). One item is in work at a time.
// The result register decouples the two sides: a new item is taken while
//   the last result waits; if out_tready stays low the next result is held
//   inside and in_tready stays low until the output register frees up.
// Reset: the sequence is unstarted, perm_size is 16, no result pending.
//   List contents are undefined until loaded.
`default_nettype none

module heap_permutation_stepper_core
  import hps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,   // [3:0] elem_index, [19:4] elem_value, pad
  input  wire logic [1:0]        in_tuser,   // [1:0] func
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // [15:0] read_value
  output logic [1:0]             out_tuser   // [1:0] status
);

  hps_state_t state_r, state_nxt;
  logic started_r, started_nxt;
  logic [SIZE_W-1:0] perm_size_r;
  logic [SIZE_W-1:0] eff_size;

  status_t res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0] res_value_r, res_value_nxt;
  logic [ADDR_W-1:0] swap_a_r, swap_a_nxt;
  logic [ADDR_W-1:0] swap_b_r, swap_b_nxt;
  logic [VALUE_WIDTH-1:0] tmp_r, tmp_nxt;

  logic out_tvalid_r, out_tvalid_nxt;
  logic [15:0] out_tdata_r, out_tdata_nxt;
  logic [1:0] out_tuser_r, out_tuser_nxt;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  ctr_cmd_t ctr_cmd;
  ctr_hit_t ctr_hit;

  func_t in_func;
  logic [IDX_W-1:0] in_idx;
  logic [VALUE_WIDTH-1:0] in_val;
  logic push;

  assign in_func = func_t'(in_tuser);
  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_val  = in_tdata[IDX_W +: VALUE_WIDTH];

  assign eff_size = (perm_size_r > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : perm_size_r;

  hps_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hps_counters u_ctr (
    .clk     (clk),
    .eff_size(eff_size),
    .cmd     (ctr_cmd),
    .hit     (ctr_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    started_nxt    = started_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    swap_a_nxt     = swap_a_r;
    swap_b_nxt     = swap_b_r;
    tmp_nxt        = tmp_r;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(in_idx);
    ram_wdata      = in_val;
    ram_raddr      = ADDR_W'(in_idx);
    ctr_cmd        = '0;
    push           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_status_nxt = STAT_ACCESS;
          res_value_nxt  = '0;
          state_nxt      = S_FINISH;
          case (in_func)
            FN_LOAD: begin
              ram_we = 1'b1;
            end
            FN_RESTART: begin
              started_nxt = 1'b0;
            end
            FN_READ: begin
              state_nxt = S_READ;
            end
            FN_NEXT: begin
              if (eff_size == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else if (eff_size == SIZE_W'(1)) begin
                res_status_nxt = STAT_DONE;
              end else if (!started_r) begin
                started_nxt       = 1'b1;
                ctr_cmd.clear_all = 1'b1;
                res_status_nxt    = STAT_NEW;
              end else if (ctr_hit.found) begin
                ctr_cmd.step   = 1'b1;
                res_status_nxt = STAT_NEW;
                // odd position swaps with its counter, even with position 0
                if (ctr_hit.pos[0]) begin
                  swap_a_nxt = ctr_hit.pos;
                  swap_b_nxt = ctr_hit.cnt;
                end else begin
                  swap_a_nxt = '0;
                  swap_b_nxt = ctr_hit.pos;
                end
                ram_raddr = swap_a_nxt;
                state_nxt = S_SWAP_RB;
              end else begin
                started_nxt    = 1'b0;
                res_status_nxt = STAT_DONE;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        res_value_nxt = ram_rdata;
        state_nxt     = S_FINISH;
      end
      S_SWAP_RB: begin
        ram_raddr = swap_b_r;
        tmp_nxt   = ram_rdata;
        state_nxt = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        ram_we    = 1'b1;
        ram_waddr = swap_a_r;
        ram_wdata = ram_rdata;
        state_nxt = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = swap_b_r;
        ram_wdata = tmp_r;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (push) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = res_value_r;
      out_tuser_nxt  = res_status_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      perm_size_r  <= SIZE_W'(MAX_SIZE);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        perm_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    swap_a_r     <= swap_a_nxt;
    swap_b_r     <= swap_b_nxt;
    tmp_r        <= tmp_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a swap always touches two distinct list positions
  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP_RB) |-> (swap_a_r != swap_b_r))
    else $error("swap addresses collide");

  // the second write of a swap always ends in a new-permutation result
  a_swap_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP_WB) |=> (state_r == S_FINISH && res_status_r == STAT_NEW))
    else $error("swap did not report a new permutation");

  // the output register fills only from the finish state
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_FINISH))
    else $error("result pushed outside finish state");

  // the sequence drops back to unstarted only on a restart or a Next
  a_started_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(started_r) |-> $past(state_r == S_IDLE && in_tvalid &&
                              (in_func == FN_RESTART || in_func == FN_NEXT)))
    else $error("started cleared without restart or finish");

endmodule

`default_nettype wire
